// ===== hdl/ajs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajs_pkg
// Types, constants and helpers shared by the Arakawa Jacobian stencil block.
// ----------------------------------------------------------------------------
package ajs_pkg;

  localparam int MAX_ROWS     = 128;
  localparam int MAX_COLS     = 128;
  localparam int SAMPLE_WIDTH = 32;
  localparam int DEPTH        = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W       = $clog2(DEPTH);

  localparam int ACC_W  = 72;
  localparam int WIDE_W = 104;

  localparam logic [1:0] REG_ROWS     = 2'd0;
  localparam logic [1:0] REG_COLS     = 2'd1;
  localparam logic [1:0] REG_MANTISSA = 2'd2;
  localparam logic [1:0] REG_SHIFT    = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // neighbor slots, in read order
  localparam logic [2:0] NB_JE = 3'd0;
  localparam logic [2:0] NB_JW = 3'd1;
  localparam logic [2:0] NB_NI = 3'd2;
  localparam logic [2:0] NB_SI = 3'd3;
  localparam logic [2:0] NB_NE = 3'd4;
  localparam logic [2:0] NB_NW = 3'd5;
  localparam logic [2:0] NB_SE = 3'd6;
  localparam logic [2:0] NB_SW = 3'd7;

  localparam logic [3:0] NUM_TERMS = 4'd10;

  typedef struct packed {
    logic              op;
    logic [6:0]        row;
    logic [6:0]        col;
    logic signed [31:0] sample_a;
    logic signed [31:0] sample_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] jacobian_out;
    logic               saturated;
    logic               range_error;
  } out_item_t;

  typedef struct packed {
    logic       start;
    logic       rd_en;
    logic [2:0] rd_idx;
    logic       mac_en;
    logic [3:0] mac_idx;
    logic       acc_clr;
    logic       scl_en;
    logic [1:0] scl_idx;
    logic       shift_en;
    logic       out_load;
    logic       out_err;
  } dp_cmd_t;

  typedef struct packed {
    logic in_grid;
    logic out_free;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [6:0] r, logic [6:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(MAX_COLS) + 32'(c);
    return a[ADDR_W-1:0];
  endfunction

  function automatic logic [31:0] narrow_sample(logic [31:0] v);
    logic signed [SAMPLE_WIDTH-1:0] t;
    t = v[SAMPLE_WIDTH-1:0];
    return 32'(t);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/arakawa_jacobian_stencil_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// arakawa_jacobian_stencil_top
// Arakawa nine-point Jacobian over two fields on a doubly periodic grid.
// ----------------------------------------------------------------------------
// A load item writes one cell of both fields and gives no item out; a load
// outside the grid is dropped. A query item runs from acceptance to its
// result through eight neighbor reads from the single-port field memories
// (one cell per cycle), ten terms through one shared 34x34 MAC, three slices
// of the scale multiply, a shift and the output stage. One query is in flight
// at a time; a finished result waits in the output register while the next
// item is taken. Out-of-grid queries return zero with range_error set. The
// memories are not cleared: a query that touches a never-loaded cell returns
// an undefined value.
// ----------------------------------------------------------------------------
module arakawa_jacobian_stencil_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire ajs_pkg::in_item_t  in_data,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      ajs_pkg::out_item_t out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  logic [7:0]  grid_rows, grid_cols;
  logic [31:0] scale_mantissa;
  logic [5:0]  scale_shift;
  logic        cfg_we;
  logic        idle, in_accept;

  ajs_pkg::dp_cmd_t  cmd;
  ajs_pkg::dp_stat_t stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows      <= 8'd128;
      grid_cols      <= 8'd128;
      scale_mantissa <= '0;
      scale_shift    <= '0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        ajs_pkg::REG_ROWS:     grid_rows      <= pwdata[7:0];
        ajs_pkg::REG_COLS:     grid_cols      <= pwdata[7:0];
        ajs_pkg::REG_MANTISSA: scale_mantissa <= pwdata;
        ajs_pkg::REG_SHIFT:    scale_shift    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ajs_pkg::REG_ROWS:     prdata = 32'(grid_rows);
      ajs_pkg::REG_COLS:     prdata = 32'(grid_cols);
      ajs_pkg::REG_MANTISSA: prdata = scale_mantissa;
      ajs_pkg::REG_SHIFT:    prdata = 32'(scale_shift);
      default:               prdata = '0;
    endcase
  end

  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;

  ajs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .in_op     (in_data.op),
    .stat      (stat),
    .idle      (idle),
    .cmd       (cmd)
  );

  ajs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_accept      (in_accept),
    .in_data        (in_data),
    .grid_rows      (grid_rows),
    .grid_cols      (grid_cols),
    .scale_mantissa (scale_mantissa),
    .scale_shift    (scale_shift),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/ajs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajs_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ajs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== hdl/ajs_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajs_ctrl
// Sequencer for one query: neighbor reads, term MACs, scaling, output.
// ----------------------------------------------------------------------------
module ajs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_accept,
  input  wire logic             in_op,
  input  wire ajs_pkg::dp_stat_t stat,
  output      logic             idle,
  output      ajs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_READ   = 9'b000000010,
    S_RWAIT  = 9'b000000100,
    S_MAC    = 9'b000001000,
    S_DRAIN  = 9'b000010000,
    S_SCALE  = 9'b000100000,
    S_SDRAIN = 9'b001000000,
    S_SHIFT  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t     state, state_next;
  logic [3:0] cnt, cnt_next;
  logic       err, err_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    err_next   = err;
    cmd        = '0;
    cmd.rd_idx  = cnt[2:0];
    cmd.mac_idx = cnt;
    cmd.scl_idx = cnt[1:0];
    cmd.out_err = err;
    unique case (state)
      S_IDLE: begin
        if (in_accept && in_op == ajs_pkg::OP_QUERY) begin
          cmd.start = 1'b1;
          cnt_next  = '0;
          err_next  = !stat.in_grid;
          state_next = stat.in_grid ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        cnt_next  = cnt + 4'd1;
        if (cnt[2:0] == ajs_pkg::NB_SW) begin
          state_next = S_RWAIT;
        end
      end
      S_RWAIT: begin
        cmd.acc_clr = 1'b1;
        cnt_next    = '0;
        state_next  = S_MAC;
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        cnt_next   = cnt + 4'd1;
        if (cnt == ajs_pkg::NUM_TERMS - 4'd1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_next   = '0;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scl_en = 1'b1;
        cnt_next   = cnt + 4'd1;
        if (cnt == 4'd2) begin
          state_next = S_SDRAIN;
        end
      end
      S_SDRAIN: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_en = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      err   <= err_next;
    end
  end

  assign idle = (state == S_IDLE);

`ifndef SYNTHESIS
  a_read_count: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> cnt <= 4'd7)
    else $error("read counter out of range");
  a_mac_count: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> cnt < ajs_pkg::NUM_TERMS)
    else $error("term counter out of range");
`endif

endmodule
`default_nettype wire

// ===== hdl/ajs_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ajs_dp
// Field memories, neighbor registers, MAC, scaling multiply and output stage.
// ----------------------------------------------------------------------------
module ajs_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ajs_pkg::dp_cmd_t  cmd,
  output      ajs_pkg::dp_stat_t stat,
  input  wire logic              in_accept,
  input  wire ajs_pkg::in_item_t in_data,
  input  wire logic [7:0]        grid_rows,
  input  wire logic [7:0]        grid_cols,
  input  wire logic [31:0]       scale_mantissa,
  input  wire logic [5:0]        scale_shift,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      ajs_pkg::out_item_t out_data
);

  logic [15:0] nr, nc;
  logic        in_grid;
  logic [15:0] n_c, s_c, e_c, w_c;

  assign nr = (16'(grid_rows) > 16'(ajs_pkg::MAX_ROWS)) ? 16'(ajs_pkg::MAX_ROWS)
                                                        : 16'(grid_rows);
  assign nc = (16'(grid_cols) > 16'(ajs_pkg::MAX_COLS)) ? 16'(ajs_pkg::MAX_COLS)
                                                        : 16'(grid_cols);
  assign in_grid = (16'(in_data.row) < nr) && (16'(in_data.col) < nc);

  assign n_c = (16'(in_data.row) + 16'd1 == nr) ? 16'd0 : 16'(in_data.row) + 16'd1;
  assign s_c = (in_data.row == 7'd0) ? nr - 16'd1 : 16'(in_data.row) - 16'd1;
  assign e_c = (16'(in_data.col) + 16'd1 == nc) ? 16'd0 : 16'(in_data.col) + 16'd1;
  assign w_c = (in_data.col == 7'd0) ? nc - 16'd1 : 16'(in_data.col) - 16'd1;

  logic [6:0] rj, ri, rn, rs, re, rw;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rj <= in_data.row;
      ri <= in_data.col;
      rn <= n_c[6:0];
      rs <= s_c[6:0];
      re <= e_c[6:0];
      rw <= w_c[6:0];
    end
  end

  // memory port
  logic                       load_we;
  logic [ajs_pkg::ADDR_W-1:0] rd_addr, ram_addr;
  logic [31:0]                ram_a_rdata, ram_b_rdata;

  assign load_we = in_accept && in_data.op == ajs_pkg::OP_LOAD && in_grid;

  always_comb begin
    case (cmd.rd_idx)
      ajs_pkg::NB_JE: rd_addr = ajs_pkg::cell_addr(rj, re);
      ajs_pkg::NB_JW: rd_addr = ajs_pkg::cell_addr(rj, rw);
      ajs_pkg::NB_NI: rd_addr = ajs_pkg::cell_addr(rn, ri);
      ajs_pkg::NB_SI: rd_addr = ajs_pkg::cell_addr(rs, ri);
      ajs_pkg::NB_NE: rd_addr = ajs_pkg::cell_addr(rn, re);
      ajs_pkg::NB_NW: rd_addr = ajs_pkg::cell_addr(rn, rw);
      ajs_pkg::NB_SE: rd_addr = ajs_pkg::cell_addr(rs, re);
      default:        rd_addr = ajs_pkg::cell_addr(rs, rw);
    endcase
  end

  assign ram_addr = cmd.rd_en ? rd_addr : ajs_pkg::cell_addr(in_data.row, in_data.col);

  ajs_ram #(.WIDTH(32), .DEPTH(ajs_pkg::DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata (ajs_pkg::narrow_sample(in_data.sample_a)),
    .rdata (ram_a_rdata)
  );

  ajs_ram #(.WIDTH(32), .DEPTH(ajs_pkg::DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (load_we),
    .addr  (ram_addr),
    .wdata (ajs_pkg::narrow_sample(in_data.sample_b)),
    .rdata (ram_b_rdata)
  );

  // neighbor capture, in the cycle after the read
  logic               rd_vld;
  logic [2:0]         rd_slot;
  logic signed [31:0] a_q [8];
  logic signed [31:0] b_q [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
    rd_slot <= cmd.rd_idx;
    if (rd_vld) begin
      a_q[rd_slot] <= ram_a_rdata;
      b_q[rd_slot] <= ram_b_rdata;
    end
  end

  // term select and MAC
  logic signed [33:0] aje, ajw, ani, asi, ane, anw, ase, asw;
  logic signed [33:0] bje, bjw, bni, bsi, bne, bnw, bse, bsw;
  logic signed [33:0] tx, ty;
  logic signed [67:0] mul_c, prod;
  logic               prod_vld;
  logic signed [ajs_pkg::ACC_W-1:0] acc;

  assign aje = 34'(a_q[ajs_pkg::NB_JE]);
  assign ajw = 34'(a_q[ajs_pkg::NB_JW]);
  assign ani = 34'(a_q[ajs_pkg::NB_NI]);
  assign asi = 34'(a_q[ajs_pkg::NB_SI]);
  assign ane = 34'(a_q[ajs_pkg::NB_NE]);
  assign anw = 34'(a_q[ajs_pkg::NB_NW]);
  assign ase = 34'(a_q[ajs_pkg::NB_SE]);
  assign asw = 34'(a_q[ajs_pkg::NB_SW]);
  assign bje = 34'(b_q[ajs_pkg::NB_JE]);
  assign bjw = 34'(b_q[ajs_pkg::NB_JW]);
  assign bni = 34'(b_q[ajs_pkg::NB_NI]);
  assign bsi = 34'(b_q[ajs_pkg::NB_SI]);
  assign bne = 34'(b_q[ajs_pkg::NB_NE]);
  assign bnw = 34'(b_q[ajs_pkg::NB_NW]);
  assign bse = 34'(b_q[ajs_pkg::NB_SE]);
  assign bsw = 34'(b_q[ajs_pkg::NB_SW]);

  always_comb begin
    case (cmd.mac_idx)
      4'd0:    begin tx = aje - ajw; ty = bni - bsi; end
      4'd1:    begin tx = asi - ani; ty = bje - bjw; end
      4'd2:    begin tx = aje;       ty = bne - bse; end
      4'd3:    begin tx = -ajw;      ty = bnw - bsw; end
      4'd4:    begin tx = -ani;      ty = bne - bnw; end
      4'd5:    begin tx = asi;       ty = bse - bsw; end
      4'd6:    begin tx = ane;       ty = bni - bje; end
      4'd7:    begin tx = -asw;      ty = bjw - bsi; end
      4'd8:    begin tx = -anw;      ty = bni - bjw; end
      default: begin tx = ase;       ty = bje - bsi; end
    endcase
  end

  assign mul_c = tx * ty;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mac_en;
    end
    prod <= mul_c;
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ajs_pkg::ACC_W'(prod);
    end
  end

  // scale: acc * mantissa in three slices of acc (32, 32 and 8 bits), top slice signed
  logic signed [32:0] chunk, m_s;
  logic signed [65:0] pp_c, pp;
  logic               pp_vld;
  logic [1:0]         pp_slot;
  logic signed [ajs_pkg::WIDE_W-1:0] wide, pp_ext, shifted;

  always_comb begin
    case (cmd.scl_idx)
      2'd0:    chunk = {1'b0, acc[31:0]};
      2'd1:    chunk = {1'b0, acc[63:32]};
      default: chunk = 33'($signed(acc[ajs_pkg::ACC_W-1:64]));
    endcase
  end

  assign m_s  = {1'b0, scale_mantissa};
  assign pp_c = chunk * m_s;

  always_comb begin
    case (pp_slot)
      2'd0:    pp_ext = ajs_pkg::WIDE_W'(pp);
      2'd1:    pp_ext = ajs_pkg::WIDE_W'(pp) <<< 32;
      default: pp_ext = ajs_pkg::WIDE_W'(pp) <<< 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_vld <= 1'b0;
    end else begin
      pp_vld <= cmd.scl_en;
    end
    pp      <= pp_c;
    pp_slot <= cmd.scl_idx;
    if (cmd.acc_clr) begin
      wide <= '0;
    end else if (pp_vld) begin
      wide <= wide + pp_ext;
    end
    if (cmd.shift_en) begin
      shifted <= wide >>> (7'(scale_shift) + 7'd16);
    end
  end

  // saturation and output register
  logic        fits;
  logic [31:0] sat_val;

  assign fits    = (shifted[ajs_pkg::WIDE_W-1:31] == '0) || (&shifted[ajs_pkg::WIDE_W-1:31]);
  assign sat_val = fits ? shifted[31:0]
                 : (shifted[ajs_pkg::WIDE_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data.jacobian_out <= cmd.out_err ? 32'sd0 : sat_val;
      out_data.saturated    <= cmd.out_err ? 1'b0 : !fits;
      out_data.range_error  <= cmd.out_err;
    end
  end

  assign stat.in_grid  = in_grid;
  assign stat.out_free = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !cmd.out_load)
    else $error("pending item overwritten");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_error |->
      out_data.jacobian_out == 32'sd0 && !out_data.saturated)
    else $error("range error item carries a value");
`endif

endmodule
`default_nettype wire

// ===== verif/ajs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ajs_checker
// Watches the item channels and the register port of the Jacobian stencil,
// keeps its own copy of both fields and the registers, predicts each query
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module ajs_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire ajs_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire ajs_pkg::out_item_t out_data,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output int                      errors,
  output int                      pending
);

  logic [31:0] field_a [ajs_pkg::DEPTH];
  logic [31:0] field_b [ajs_pkg::DEPTH];
  logic [7:0]  rows_q, cols_q;
  logic [31:0] mant_q;
  logic [5:0]  shift_q;
  ajs_pkg::out_item_t expected_q[$];

  assign pending = expected_q.size();

  function automatic logic signed [71:0] cell_value(bit use_b, int r, int c);
    logic [31:0] v;
    v = use_b ? field_b[r * ajs_pkg::MAX_COLS + c] : field_a[r * ajs_pkg::MAX_COLS + c];
    return 72'($signed(v));
  endfunction

  function automatic ajs_pkg::out_item_t jacobian_at(int j, int i, int nr, int nc);
    ajs_pkg::out_item_t res;
    int n, s, e, w;
    logic signed [71:0] aje, ajw, ani, asi, ane, anw, ase, asw;
    logic signed [71:0] bje, bjw, bni, bsi, bne, bnw, bse, bsw, acc;
    logic signed [111:0] wide, m, scaled;
    n = (j + 1 == nr) ? 0 : j + 1;
    s = (j == 0) ? nr - 1 : j - 1;
    e = (i + 1 == nc) ? 0 : i + 1;
    w = (i == 0) ? nc - 1 : i - 1;
    aje = cell_value(0, j, e); ajw = cell_value(0, j, w);
    ani = cell_value(0, n, i); asi = cell_value(0, s, i);
    ane = cell_value(0, n, e); anw = cell_value(0, n, w);
    ase = cell_value(0, s, e); asw = cell_value(0, s, w);
    bje = cell_value(1, j, e); bjw = cell_value(1, j, w);
    bni = cell_value(1, n, i); bsi = cell_value(1, s, i);
    bne = cell_value(1, n, e); bnw = cell_value(1, n, w);
    bse = cell_value(1, s, e); bsw = cell_value(1, s, w);
    acc = (aje - ajw) * (bni - bsi) - (ani - asi) * (bje - bjw)
        + aje * (bne - bse) - ajw * (bnw - bsw) - ani * (bne - bnw) + asi * (bse - bsw)
        + ane * (bni - bje) - asw * (bjw - bsi) - anw * (bni - bjw) + ase * (bje - bsi);
    wide = acc;
    m = {80'b0, mant_q};
    scaled = (wide * m) >>> (int'(shift_q) + 16);
    res.range_error = 1'b0;
    if (scaled > 112'sd2147483647) begin
      res.jacobian_out = 32'h7FFF_FFFF;
      res.saturated = 1'b1;
    end else if (scaled < -112'sd2147483648) begin
      res.jacobian_out = 32'h8000_0000;
      res.saturated = 1'b1;
    end else begin
      res.jacobian_out = scaled[31:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    int nr, nc;
    ajs_pkg::out_item_t exp_item;
    if (rst) begin
      rows_q <= 8'd128;
      cols_q <= 8'd128;
      mant_q <= '0;
      shift_q <= '0;
      expected_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          ajs_pkg::REG_ROWS:     rows_q <= pwdata[7:0];
          ajs_pkg::REG_COLS:     cols_q <= pwdata[7:0];
          ajs_pkg::REG_MANTISSA: mant_q <= pwdata;
          ajs_pkg::REG_SHIFT:    shift_q <= pwdata[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        nr = (rows_q > ajs_pkg::MAX_ROWS) ? ajs_pkg::MAX_ROWS : rows_q;
        nc = (cols_q > ajs_pkg::MAX_COLS) ? ajs_pkg::MAX_COLS : cols_q;
        if (in_data.op == ajs_pkg::OP_LOAD) begin
          if (in_data.row < nr && in_data.col < nc) begin
            field_a[in_data.row * ajs_pkg::MAX_COLS + in_data.col] = in_data.sample_a;
            field_b[in_data.row * ajs_pkg::MAX_COLS + in_data.col] = in_data.sample_b;
          end
        end else if (in_data.row < nr && in_data.col < nc) begin
          expected_q.push_back(jacobian_at(in_data.row, in_data.col, nr, nc));
        end else begin
          exp_item = '{jacobian_out: '0, saturated: 1'b0, range_error: 1'b1};
          expected_q.push_back(exp_item);
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item %p", out_data);
          errors <= errors + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data !== exp_item) begin
            if (errors < 10)
              $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                       exp_item.jacobian_out, exp_item.saturated, exp_item.range_error,
                       out_data.jacobian_out, out_data.saturated, out_data.range_error);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== verif/tb_arakawa_jacobian_stencil_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arakawa_jacobian_stencil_top
// Drives loads and queries into the Jacobian stencil across several grid
// sizes and scale settings, with random idling on both channels. In-grid
// queries are issued only once all nine cells around them hold loaded data.
// ----------------------------------------------------------------------------
module tb_arakawa_jacobian_stencil_top;

  localparam int WATCHDOG_LIMIT = 50000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  ajs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ajs_pkg::out_item_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;

  int tx_idle_pct = 12, rx_idle_pct = 74;
  int sent = 0, grid_r = 128, grid_c = 128, idle_cycles = 0;
  bit loaded [ajs_pkg::DEPTH];

  always #5 clk = ~clk;

  arakawa_jacobian_stencil_top dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ajs_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .errors, .pending
  );

  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("arakawa_jacobian_stencil_top regression: fail");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send(ajs_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent == 600) begin tx_idle_pct = 74; rx_idle_pct = 12; end
    if (sent == 1200) begin tx_idle_pct = 0; rx_idle_pct = 0; end
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(131071)) - 65536);
      2: return 32'($signed($urandom_range(2047)) - 1024) <<< 16;
      default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic load_cell(int r, int c, logic [31:0] a, logic [31:0] b);
    ajs_pkg::in_item_t it;
    it = '{op: ajs_pkg::OP_LOAD, row: 7'(r), col: 7'(c), sample_a: a, sample_b: b};
    send(it);
    if (r < grid_r && c < grid_c) loaded[r * ajs_pkg::MAX_COLS + c] = 1'b1;
  endtask

  task automatic query_cell(int r, int c);
    ajs_pkg::in_item_t it;
    int rr, cc;
    if (r < grid_r && c < grid_c) begin
      for (int dr = -1; dr <= 1; dr++)
        for (int dc = -1; dc <= 1; dc++) begin
          rr = (r + dr + grid_r) % grid_r;
          cc = (c + dc + grid_c) % grid_c;
          if (!loaded[rr * ajs_pkg::MAX_COLS + cc])
            load_cell(rr, cc, rand_sample(), rand_sample());
        end
    end
    it = '{op: ajs_pkg::OP_QUERY, row: 7'(r), col: 7'(c),
           sample_a: $urandom(), sample_b: $urandom()};
    send(it);
  endtask

  task automatic set_grid(int rows, int cols, logic [31:0] mant, int shift);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (30) @(posedge clk);
    reg_write(ajs_pkg::REG_ROWS, rows);
    reg_write(ajs_pkg::REG_COLS, cols);
    reg_write(ajs_pkg::REG_MANTISSA, mant);
    reg_write(ajs_pkg::REG_SHIFT, shift);
    grid_r = rows > ajs_pkg::MAX_ROWS ? ajs_pkg::MAX_ROWS : rows;
    grid_c = cols > ajs_pkg::MAX_COLS ? ajs_pkg::MAX_COLS : cols;
  endtask

  int rows_tab [8] = '{128, 1, 3, 2, 128, 255, 0, 17};
  int cols_tab [8] = '{128, 1, 5, 128, 1, 200, 0, 9};
  logic [31:0] mant_tab [8] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_5555, 32'h0,
                               32'h0000_1555, 32'h8000_0000, 32'h1, 32'h0000_AAAA};
  int shift_tab [8] = '{0, 63, 2, 5, 0, 40, 0, 20};

  initial begin
    int r, c;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_grid(128, 128, 32'h0001_0000, 4);
    load_cell(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    load_cell(127, 127, 32'h8000_0000, 32'h7FFF_FFFF);
    load_cell(0, 1, 32'h0, 32'hFFFF_FFFF);
    query_cell(0, 0);
    query_cell(127, 127);
    query_cell(127, 0);
    query_cell(0, 127);
    query_cell(64, 64);

    for (int p = 0; p < 8; p++) begin
      set_grid(rows_tab[p], cols_tab[p], mant_tab[p], shift_tab[p]);
      query_cell(127, 127);
      query_cell(0, 0);
      repeat (55) begin
        case ($urandom_range(19))
          0: begin
            r = $urandom_range(127); c = $urandom_range(127);
            if ($urandom_range(1)) query_cell(r, c);
            else load_cell(r, c, $urandom(), $urandom());
          end
          1, 2, 3, 4: if (grid_r > 0 && grid_c > 0)
            load_cell($urandom_range(grid_r - 1), $urandom_range(grid_c - 1),
                      rand_sample(), rand_sample());
          default: if (grid_r > 0 && grid_c > 0)
            query_cell($urandom_range(grid_r - 1), $urandom_range(grid_c - 1));
          else query_cell($urandom_range(127), $urandom_range(127));
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("arakawa_jacobian_stencil_top regression: pass");
    else $display("arakawa_jacobian_stencil_top regression: fail");
    $finish;
  end
endmodule
